// ===== rtl/core/bid_pkg.sv =====
// Shared types and constants for the bounded indexed deque.
// Request codes, status codes, field widths and the result record.
// No dependencies.
package bid_pkg;

  // Fixed field widths on the stream ports
  localparam int REQ_BITS    = 4;
  localparam int POS_BITS    = 7;
  localparam int DATA_BITS   = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 7;

  // Default sizing of the store
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Request codes
  typedef enum logic [REQ_BITS-1:0] {
    REQ_PUSH_BACK  = 4'd0,
    REQ_PUSH_FRONT = 4'd1,
    REQ_POP_FRONT  = 4'd2,
    REQ_POP_BACK   = 4'd3,
    REQ_PEEK_BACK  = 4'd4,
    REQ_PEEK_FRONT = 4'd5,
    REQ_READ_AT    = 4'd6,
    REQ_INSERT_AT  = 4'd7,
    REQ_REMOVE_AT  = 4'd8,
    REQ_CLEAR      = 4'd9
  } req_t;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_ERR  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

  // One result transaction
  typedef struct packed {
    logic [DATA_BITS-1:0]   data;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  count;
  } res_t;

endpackage

// ===== rtl/core/bid_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old contents.
// No dependencies.
module bid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bid_seq.sv =====
// Request sequencer for the deque: decodes a request, checks it against the
// count, drives the store RAM and runs the shift loop for middle insert/remove.
// Depends on bid_pkg.
module bid_seq #(
  parameter int CAPACITY   = bid_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bid_pkg::DATA_WIDTH_DEF,
  localparam int PW        = $clog2(CAPACITY)
) (
  input  logic                                clk,
  input  logic                                rst,
  // request side
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bid_pkg::REQ_BITS-1:0]        in_req,
  input  logic [bid_pkg::POS_BITS-1:0]        in_pos,
  input  logic signed [bid_pkg::DATA_BITS-1:0] in_value,
  // result side
  output logic                                res_valid,
  input  logic                                res_ready,
  output bid_pkg::res_t                       res,
  // store RAM
  output logic                                mem_rd_en,
  output logic [PW-1:0]                       mem_rd_addr,
  input  logic [DATA_WIDTH-1:0]               mem_rd_data,
  output logic                                mem_wr_en,
  output logic [PW-1:0]                       mem_wr_addr,
  output logic [DATA_WIDTH-1:0]               mem_wr_data
);
  import bid_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_BITS) ? CW : POS_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_READ  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_WRITE = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  // Circular pointer step with wrap at CAPACITY
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(CAPACITY - 1) : p - 1'b1;
  endfunction

  // control state
  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [PW-1:0] fp, fp_next;
  logic          pend_v, pend_v_next;

  // payload
  req_t                  req;
  logic [POS_BITS-1:0]   pos;
  logic [DATA_WIDTH-1:0] word;
  logic [PW-1:0]         ra, ra_next;
  logic [CW-1:0]         rem, rem_next;
  logic [PW-1:0]         pend_wa, pend_wa_next;
  logic [DATA_BITS-1:0]  res_data, res_data_next;
  logic [STATUS_BITS-1:0] res_status, res_status_next;

  // derived values
  logic signed [63:0] value_ext;
  logic [63:0]        rd_ext;
  logic [XW-1:0]      cnt_x, pos_x, li_x;
  logic [PW:0]        slot_sum;
  logic [PW-1:0]      slot;
  logic               full, empty, accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESP);

  // store word is the low bits of the sign-extended input
  assign value_ext = 64'(in_value);
  assign rd_ext    = 64'(mem_rd_data);

  assign cnt_x = XW'(cnt);
  assign pos_x = XW'(pos);
  assign full  = (cnt == CW'(CAPACITY));
  assign empty = (cnt == '0);

  // list index to store slot: one add and one wrap subtract
  assign slot_sum = {1'b0, fp} + {1'b0, PW'(li_x)};
  assign slot     = (slot_sum >= (PW+1)'(CAPACITY)) ?
                    PW'(slot_sum - (PW+1)'(CAPACITY)) : PW'(slot_sum);

  // list index that the current request addresses
  always_comb begin
    li_x = '0;
    case (req)
      REQ_PUSH_BACK, REQ_INSERT_AT: li_x = cnt_x;
      REQ_POP_BACK, REQ_PEEK_BACK:  li_x = cnt_x - 1'b1;
      REQ_READ_AT, REQ_REMOVE_AT:   li_x = pos_x;
      default:                      li_x = '0;
    endcase
  end

  // sequencer next-state and RAM control
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    fp_next         = fp;
    ra_next         = ra;
    rem_next        = rem;
    pend_v_next     = 1'b0;
    pend_wa_next    = pend_wa;
    res_data_next   = res_data;
    res_status_next = res_status;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = slot;
    mem_wr_en       = pend_v;
    mem_wr_addr     = pend_wa;
    mem_wr_data     = pend_v ? mem_rd_data : word;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        // rejected unless an arm below says otherwise
        res_data_next   = DATA_BITS'(1);
        res_status_next = ST_ERR;
        state_next      = S_RESP;
        unique case (req)
          REQ_PUSH_BACK: begin
            res_data_next = '0;
            if (full) begin
              res_status_next = ST_FULL;
            end else begin
              res_status_next = ST_OK;
              mem_wr_en       = 1'b1;
              mem_wr_addr     = slot;
              cnt_next        = cnt + 1'b1;
            end
          end
          REQ_PUSH_FRONT: begin
            res_data_next = '0;
            if (full) begin
              res_status_next = ST_FULL;
            end else begin
              res_status_next = ST_OK;
              mem_wr_en       = 1'b1;
              mem_wr_addr     = ptr_dec(fp);
              fp_next         = ptr_dec(fp);
              cnt_next        = cnt + 1'b1;
            end
          end
          REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_POP_BACK, REQ_PEEK_BACK: begin
            if (!empty) begin
              res_status_next = ST_OK;
              mem_rd_en       = 1'b1;
              state_next      = S_READ;
              if (req == REQ_POP_FRONT) begin
                fp_next  = ptr_inc(fp);
                cnt_next = cnt - 1'b1;
              end else if (req == REQ_POP_BACK) begin
                cnt_next = cnt - 1'b1;
              end
            end
          end
          REQ_READ_AT: begin
            if (pos_x < cnt_x) begin
              res_status_next = ST_OK;
              mem_rd_en       = 1'b1;
              state_next      = S_READ;
            end
          end
          REQ_INSERT_AT: begin
            if (pos_x <= cnt_x) begin
              res_data_next = '0;
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                // move entries pos..cnt-1 up one slot, starting at the back
                res_status_next = ST_OK;
                ra_next         = ptr_dec(slot);
                rem_next        = CW'(cnt_x - pos_x);
                cnt_next        = cnt + 1'b1;
                state_next      = S_SHIFT;
              end
            end
          end
          REQ_REMOVE_AT: begin
            if (pos_x < cnt_x) begin
              // read the victim, then move entries pos+1..cnt-1 down one slot
              res_status_next = ST_OK;
              mem_rd_en       = 1'b1;
              ra_next         = ptr_inc(slot);
              rem_next        = CW'(cnt_x - pos_x - 1'b1);
              cnt_next        = cnt - 1'b1;
              state_next      = S_READ;
            end
          end
          REQ_CLEAR: begin
            res_data_next   = '0;
            res_status_next = ST_OK;
            cnt_next        = '0;
            fp_next         = '0;
          end
          default: begin
          end
        endcase
      end

      S_READ: begin
        res_data_next = rd_ext[DATA_BITS-1:0];
        state_next    = (req == REQ_REMOVE_AT) ? S_SHIFT : S_RESP;
      end

      // one entry moved per cycle: read at ra, write back in the next cycle
      S_SHIFT: begin
        if (rem != '0) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = ra;
          pend_v_next  = 1'b1;
          pend_wa_next = (req == REQ_INSERT_AT) ? ptr_inc(ra) : ptr_dec(ra);
          ra_next      = (req == REQ_INSERT_AT) ? ptr_dec(ra) : ptr_inc(ra);
          rem_next     = rem - 1'b1;
        end else begin
          state_next = (req == REQ_INSERT_AT) ? S_WRITE : S_RESP;
        end
      end

      // new word goes to the slot just vacated
      S_WRITE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_inc(ra);
        mem_wr_data = word;
        state_next  = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      fp     <= '0;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      fp     <= fp_next;
      pend_v <= pend_v_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req  <= req_t'(in_req);
      pos  <= in_pos;
      word <= value_ext[DATA_WIDTH-1:0];
    end
    ra         <= ra_next;
    rem        <= rem_next;
    pend_wa    <= pend_wa_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
  end

  assign res.data   = res_data;
  assign res.status = res_status;
  assign res.count  = cnt_x[COUNT_BITS-1:0];

  // the shift loop never reads the slot it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    mem_rd_en && mem_wr_en |-> mem_rd_addr != mem_wr_addr)
    else $error("store read and write hit the same slot");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a pending write-back only exists inside the shift loop
  a_pend_in_shift: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> state == S_SHIFT)
    else $error("write-back pending outside shift loop");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_CHECK)
    else $error("accepted request not decoded");

  a_resp_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> in_ready)
    else $error("sequencer not idle after result handoff");

endmodule

// ===== rtl/core/bounded_indexed_deque.sv =====
// Top level of the bounded indexed deque: stream ports, store RAM,
// request sequencer and the result output register.
// Depends on bid_pkg, bid_ram, bid_seq.
//
//  port group | dir | tdata (low bit up)          | tuser
//  s_axis_*   | in  | position[6:0], value[31:0]  | req_type[3:0]
//  m_axis_*   | out | data[31:0], count[6:0]      | status[1:0]
//
// Push, push-front, clear and rejected requests go from check to result;
// reads, peeks and pops add a store read; insert_at and remove_at run the
// shift loop, one entry per cycle through the single read and write port.
// Synchronous reset empties the list at once; store contents are not cleared.
// A result waits in the output register while the next request is taken;
// a further result holds the sequencer until the register drains.
module bounded_indexed_deque #(
  parameter int CAPACITY   = bid_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bid_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[6:0], value[38:7], zero pad
  input  logic [3:0]  s_axis_tuser,   // req_type[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // data[31:0], count[38:32], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import bid_pkg::*;

  localparam int PW = $clog2(CAPACITY);

  logic                  res_valid, res_ready;
  res_t                  res, out_res;
  logic                  mem_rd_en, mem_wr_en;
  logic [PW-1:0]         mem_rd_addr, mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data, mem_wr_data;

  bid_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bid_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_req      (s_axis_tuser[REQ_BITS-1:0]),
    .in_pos      (s_axis_tdata[POS_BITS-1:0]),
    .in_value    (signed'(s_axis_tdata[POS_BITS +: DATA_BITS])),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // output register: loads when empty or draining this cycle
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_res.count, out_res.data};
  assign m_axis_tuser = out_res.status;

endmodule
